FILE: hw/rtl/multi_button_debouncer_unit_macros.svh
// Assertion macros for the debouncer RTL.
`ifndef MULTI_BUTTON_DEBOUNCER_UNIT_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define MBD_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("debouncer check failed");
// Condition that must hold at every clock edge outside reset.
`define MBD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("debouncer invariant failed");
`else
`define MBD_ASSERT_IMP(label, clk, rst_n, pre, post)
`define MBD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif

`endif

FILE: hw/rtl/mbd_pkg.sv
// Types and constants for the multi-button debouncer.
package mbd_pkg;

	localparam int unsigned FIELD_W = 4;
	localparam int unsigned TICKS_W = 8;
	localparam logic [TICKS_W-1:0] RESET_TICKS = 8'd5;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_TICK   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] raw_buttons;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] debounced_buttons;
		logic [FIELD_W-1:0] changed_buttons;
	} result_t;

	// Control broadcast to every button cell.
	typedef struct packed {
		logic               apply;
		logic               tick;
		logic [TICKS_W-1:0] reload;
	} ctrl_t;

endpackage

FILE: hw/rtl/mbd_button_cell.sv
// Per-button state: last sample, settle counter and debounced bit.
module mbd_button_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  mbd_pkg::ctrl_t ctrl,
	input  logic          sample_bit,
	output logic          deb_cur,
	output logic          deb_nxt,
	output logic          chg
);
	import mbd_pkg::*;

	logic               last_q;
	logic               deb_q;
	logic [TICKS_W-1:0] cnt_q;
	logic [TICKS_W-1:0] cnt_d;
	logic               last_d;

	always_comb begin
		cnt_d   = cnt_q;
		last_d  = last_q;
		deb_nxt = deb_q;
		chg     = 1'b0;
		if (ctrl.tick) begin
			if (cnt_q != '0) begin
				cnt_d = cnt_q - TICKS_W'(1);
				// The counter expires on this tick; accept the held sample if it differs.
				if (cnt_d == '0 && last_q != deb_q) begin
					deb_nxt = last_q;
					chg     = 1'b1;
				end
			end
		end else begin
			last_d = sample_bit;
			if (sample_bit != last_q) begin
				cnt_d = ctrl.reload;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			deb_q  <= 1'b0;
			cnt_q  <= RESET_TICKS;
		end else if (ctrl.apply) begin
			last_q <= last_d;
			deb_q  <= deb_nxt;
			cnt_q  <= cnt_d;
		end
	end

	assign deb_cur = deb_q;

endmodule

FILE: hw/rtl/multi_button_debouncer_unit.sv
// An item goes to the input register, then its result to the result register;
// one item per cycle while res_stall is low. The input register feeds the
// button cells, whose state and the result register update in the same cycle.
// Reset (arst_n low) clears the samples and debounced bits, sets every settle
// counter and the debounce tick count to five, and empties both registers.
`include "multi_button_debouncer_unit_macros.svh"

module multi_button_debouncer_unit #(
	parameter int unsigned BUTTONS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  mbd_pkg::item_t                item,
	output logic                          res_valid,
	input  logic                          res_stall,
	output mbd_pkg::result_t              res,
	input  logic                          cfg_we,
	input  logic [mbd_pkg::TICKS_W-1:0]   cfg_wdata
);
	import mbd_pkg::*;

	logic               ticks_zero;
	logic [TICKS_W-1:0] debounce_ticks_q;
	logic               item_valid_s1;
	item_t              item_s1;
	logic               res_valid_s2;
	result_t            res_s2;
	logic               adv_s1;
	ctrl_t              ctrl;
	logic [BUTTONS-1:0] sample_vec;
	logic [BUTTONS-1:0] deb_cur_vec;
	logic [BUTTONS-1:0] deb_nxt_vec;
	logic [BUTTONS-1:0] chg_vec;
	logic [FIELD_W-1:0] deb_cur_field;
	logic [FIELD_W-1:0] deb_nxt_field;
	logic [FIELD_W-1:0] chg_field;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= RESET_TICKS;
		end else if (cfg_we) begin
			debounce_ticks_q <= cfg_wdata;
		end
	end

	// A zero count behaves as one tick.
	assign ticks_zero = (debounce_ticks_q == '0);

	// The input stage moves on when the result register is empty or being taken.
	assign adv_s1     = !res_valid_s2 || !res_stall;
	assign item_stall = item_valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		ctrl.apply  = item_valid_s1 && adv_s1;
		ctrl.tick   = (item_s1.kind == KIND_TICK);
		ctrl.reload = ticks_zero ? TICKS_W'(1) : debounce_ticks_q;
	end

	for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
		if (i < FIELD_W) begin : g_wired
			assign sample_vec[i] = item_s1.raw_buttons[i];
		end else begin : g_unwired
			assign sample_vec[i] = 1'b0;
		end

		mbd_button_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.sample_bit (sample_vec[i]),
			.deb_cur    (deb_cur_vec[i]),
			.deb_nxt    (deb_nxt_vec[i]),
			.chg        (chg_vec[i])
		);
	end

	for (genvar k = 0; k < FIELD_W; k++) begin : g_field
		if (k < BUTTONS) begin : g_used
			assign deb_cur_field[k] = deb_cur_vec[k];
			assign deb_nxt_field[k] = deb_nxt_vec[k];
			assign chg_field[k]     = chg_vec[k];
		end else begin : g_pad
			assign deb_cur_field[k] = 1'b0;
			assign deb_nxt_field[k] = 1'b0;
			assign chg_field[k]     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			res_valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			res_s2.debounced_buttons <= deb_nxt_field;
			res_s2.changed_buttons   <= chg_field;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	`MBD_ASSERT_IMP(a_sample_no_change, clk, arst_n, ctrl.apply && !ctrl.tick, res.changed_buttons == '0)
	`MBD_ASSERT_IMP(a_apply_gives_result, clk, arst_n, ctrl.apply, res_valid)
	`MBD_ASSERT_IMP(a_change_flips_bit, clk, arst_n, ctrl.apply, ((res.debounced_buttons ^ $past(deb_cur_field)) == res.changed_buttons))
	`MBD_ASSERT_ALWAYS(a_no_stall_when_empty, clk, arst_n, !(item_stall && !item_valid_s1))

endmodule

FILE: test/tb_multi_button_debouncer_unit.sv
// Self-checking testbench for the multi-button debouncer unit.
`timescale 1ns / 100ps

module tb_multi_button_debouncer_unit;
	import mbd_pkg::*;

	localparam int unsigned LATENCY     = 2;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item       = '0;
	logic               res_valid;
	logic               res_stall  = 1'b0;
	result_t            res;
	logic               cfg_we     = 1'b0;
	logic [TICKS_W-1:0] cfg_wdata  = '0;

	// Predicted block state.
	logic [TICKS_W-1:0] model_ticks  = RESET_TICKS;
	logic [FIELD_W-1:0] model_sample = '0;
	logic [FIELD_W-1:0] model_deb    = '0;
	logic [TICKS_W-1:0] model_cnt [FIELD_W];

	result_t pending_button_states [$];

	int unsigned mismatches     = 0;
	int unsigned cycles         = 0;
	int unsigned sent_count     = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_len       = 0;

	multi_button_debouncer_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[multi_button_debouncer_unit] ERROR");
			$finish;
		end
	end

	// Receiver: a requested hold-off takes priority over random stalls.
	always @(negedge clk) begin
		if (hold_len > 0) begin
			res_stall <= 1'b1;
			hold_len = hold_len - 1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_button_states.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual %h",
					$time, res);
				mismatches++;
			end else begin
				want = pending_button_states.pop_front();
				if (want.debounced_buttons !== res.debounced_buttons) begin
					$display("%0t: debounced_buttons expected %h, actual %h",
						$time, want.debounced_buttons, res.debounced_buttons);
					mismatches++;
				end
				if (want.changed_buttons !== res.changed_buttons) begin
					$display("%0t: changed_buttons expected %h, actual %h",
						$time, want.changed_buttons, res.changed_buttons);
					mismatches++;
				end
			end
		end
	end

	function automatic result_t debounce_predict(input item_t it);
		result_t            r;
		logic [FIELD_W-1:0] diff;
		logic [FIELD_W-1:0] chg;
		logic [TICKS_W-1:0] reload;
		int                 i;
		chg    = '0;
		reload = (model_ticks == '0) ? TICKS_W'(1) : model_ticks;
		if (it.kind == KIND_SAMPLE) begin
			diff = it.raw_buttons ^ model_sample;
			for (i = 0; i < FIELD_W; i++) begin
				if (diff[i]) model_cnt[i] = reload;
			end
			model_sample = it.raw_buttons;
		end else begin
			for (i = 0; i < FIELD_W; i++) begin
				if (model_cnt[i] != '0) begin
					model_cnt[i] = model_cnt[i] - TICKS_W'(1);
					if (model_cnt[i] == '0 && model_sample[i] != model_deb[i]) begin
						model_deb[i] = model_sample[i];
						chg[i]       = 1'b1;
					end
				end
			end
		end
		r.debounced_buttons = model_deb;
		r.changed_buttons   = chg;
		return r;
	endfunction

	// Offers one transaction and returns right after the edge that accepts it.
	task automatic send_item(input kind_t kind, input logic [FIELD_W-1:0] raw);
		item_t it;
		it.kind        = kind;
		it.raw_buttons = raw;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		pending_button_states.push_back(debounce_predict(it));
		sent_count++;
	endtask

	task automatic send_sample(input logic [FIELD_W-1:0] raw);
		send_item(KIND_SAMPLE, raw);
	endtask

	// The raw field is ignored on a tick, so it carries random bits.
	task automatic send_tick();
		send_item(KIND_TICK, FIELD_W'($urandom));
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_button_states.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_ticks(input logic [TICKS_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we      <= 1'b0;
		model_ticks = value;
	endtask

	task automatic test_reset_defaults();
		// Counters start at five, so the first ticks settle every button quietly.
		repeat (5) send_tick();
		send_sample(4'hF);
		repeat (5) send_tick();
	endtask

	task automatic test_min_ticks();
		write_ticks(TICKS_W'(1));
		send_sample(4'h0);
		send_tick();
		send_sample(4'hA);
		send_sample(4'h5);
		send_tick();
	endtask

	task automatic test_zero_ticks();
		// A zero count behaves as a count of one.
		write_ticks('0);
		send_sample(4'hF);
		send_tick();
		send_tick();
	endtask

	task automatic test_bounce_back();
		// The sample returns to the debounced value before the counter expires.
		write_ticks(TICKS_W'(3));
		send_sample(4'h0);
		send_tick();
		send_sample(4'hF);
		repeat (3) send_tick();
	endtask

	task automatic test_backpressure();
		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len       = 100;
		repeat (30) begin
			if ($urandom_range(0, 1)) send_tick();
			else send_sample(FIELD_W'($urandom));
		end
		// The sender waits until every expected result has come.
		drain();
	endtask

	// Mostly settle sequences: optional bounces, the final sample, then ticks.
	task automatic test_random_phase(input int unsigned n, input int unsigned idle_pct,
		input int unsigned stall_pct, input logic [TICKS_W-1:0] ticks);
		int unsigned        start;
		int unsigned        eff;
		int unsigned        k;
		logic [FIELD_W-1:0] target;
		write_ticks(ticks);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		eff            = (ticks == '0) ? 1 : ticks;
		start          = sent_count;
		while (sent_count - start < n) begin
			repeat ($urandom_range(0, 2)) send_sample(FIELD_W'($urandom));
			target = FIELD_W'($urandom);
			send_sample(target);
			k = $urandom_range(0, eff + 2);
			repeat (k) begin
				if ($urandom_range(0, 9) == 0) send_sample(target);
				else send_tick();
			end
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < FIELD_W; i++) model_cnt[i] = RESET_TICKS;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct  = 20;
		recv_stall_pct = 47;
		test_reset_defaults();
		test_min_ticks();
		test_zero_ticks();
		test_bounce_back();
		test_random_phase(600, 20, 47, TICKS_W'(3));
		test_backpressure();
		test_random_phase(550, 47, 20, TICKS_W'(1));
		test_random_phase(400, 0, 0, TICKS_W'($urandom_range(2, 12)));
		test_random_phase(300, 0, 0, TICKS_W'(255));

		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && pending_button_states.size() == 0) begin
			$display("[multi_button_debouncer_unit] OK");
		end else begin
			$display("[multi_button_debouncer_unit] ERROR");
		end
		$finish;
	end

endmodule
